// ===== hw/rtl/wffm_pkg.sv =====
// wffm_pkg: shared types, field layout and constants of the force feedback mixer
`default_nettype none

package wffm_pkg;

  // stream widths
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_W       = 20;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 10;

  // in_tdata field offsets, lowest bit first
  localparam int F_IDX_LO  = 0;
  localparam int F_EN_LO   = 2;
  localparam int F_KIND_LO = 3;
  localparam int F_PA_LO   = 7;
  localparam int F_PB_LO   = 15;
  localparam int F_PC_LO   = 23;
  localparam int F_PD_LO   = 31;
  localparam int F_AXIS_LO = 39;
  localparam int AXIS_W    = 12;

  // item kinds carried on in_tuser
  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  // slot force types
  localparam logic [3:0] FK_CONST  = 4'd0;
  localparam logic [3:0] FK_SPRING = 4'd1;
  localparam logic [3:0] FK_DAMPER = 4'd2;
  localparam logic [3:0] FK_AUTO   = 4'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SPRING_EN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_LOW   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_HIGH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DB_LOW     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DB_HIGH    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LIM  = 3'd6;

  // configuration reset values
  localparam logic [7:0] DB_LOW_RST    = 8'd127;
  localparam logic [7:0] DB_HIGH_RST   = 8'd128;
  localparam logic [9:0] RANGE_LIM_RST = 10'd1000;

  // axis full scale in thousandths
  localparam logic signed [12:0] AXIS_FULL = 13'sd1000;

  // position = floor(x * 255 / 2000) done as (x * POS_MUL) >> POS_SHIFT, x in 0..2000
  localparam int         POS_SHIFT = 24;
  localparam logic [21:0] POS_MUL  = 22'd2139096;

  // constant slot level midpoint
  localparam logic signed [8:0] CONST_MID = 9'sd128;

  // one stored force slot
  typedef struct packed {
    logic       en;
    logic [3:0] kind;
    logic [7:0] p_d;
    logic [7:0] p_c;
    logic [7:0] p_b;
    logic [7:0] p_a;
  } slot_t;

  // spring coefficient in quarters per position step (0.25 .. 4.0)
  function automatic logic [4:0] coef_q(input logic [2:0] sel);
    logic [4:0] c;
    case (sel)
      3'd0:    c = 5'd1;
      3'd1:    c = 5'd2;
      3'd2:    c = 5'd3;
      3'd3:    c = 5'd4;
      3'd4:    c = 5'd6;
      3'd5:    c = 5'd8;
      3'd6:    c = 5'd12;
      3'd7:    c = 5'd16;
      default: c = 5'd1;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/wffm_slot_mem.sv =====
// wffm_slot_mem: force slot table, one write and one registered read port
`default_nettype none

module wffm_slot_mem #(
  parameter int SLOT_COUNT = 4,
  localparam int ADDR_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  wr_en,
  input  wire [ADDR_W-1:0]     wr_addr,
  input  wire wffm_pkg::slot_t wr_slot,
  input  wire                  rd_en,
  input  wire [ADDR_W-1:0]     rd_addr,
  output wffm_pkg::slot_t      rd_slot
);
  import wffm_pkg::*;

  slot_t            mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] valid_r;
  slot_t            rd_data_r;
  logic             rd_valid_r;

  // storage write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_slot;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // per-entry written flags, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
    end
  end

  // an entry never loaded reads as a disabled all-zero slot
  assign rd_slot = rd_valid_r ? rd_data_r : '0;

endmodule

`default_nettype wire

// ===== hw/rtl/wheel_force_feedback_mixer_top.sv =====
// wheel_force_feedback_mixer_top: force feedback mixer with slot table and sample sequencer
`default_nettype none

// A load item (in_tuser low) writes one force slot; a load to a slot index
// at or above SLOT_COUNT is dropped. A sample item (in_tuser high) gives one
// force result in quarter units: range-limit push and, with the spring enabled,
// the default spring outside the dead band and the enabled slot forces,
// saturated to 20 bits. With the spring enabled a sample occupies the block
// through position multiply, spring, one visit per slot through the single read
// port of the slot memory and result; with it disabled, position multiply and
// result only. One finished result can wait in the output register while the
// next item is taken. Configuration is written through cfg_we/cfg_index/cfg_wdata.
module wheel_force_feedback_mixer_top #(
  parameter int SLOT_COUNT = 4
) (
  input  wire        clk,
  input  wire        rst_n,
  // slave stream
  input  wire        in_tvalid,
  output logic       in_tready,
  // slot_index[1:0], slot_enable[2], force_kind[6:3], param_a[14:7],
  // param_b[22:15], param_c[30:23], param_d[38:31], axis_milli[50:39], zero pad
  input  wire [wffm_pkg::IN_TDATA_W-1:0]  in_tdata,
  // kind[0]
  input  wire        in_tuser,
  // master stream
  output logic       out_tvalid,
  input  wire        out_tready,
  // force_quarters[19:0], zero pad
  output logic [wffm_pkg::OUT_TDATA_W-1:0] out_tdata,
  // configuration write port
  input  wire        cfg_we,
  input  wire [wffm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [wffm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import wffm_pkg::*;

  localparam int ADDR_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int ACC_W  = OUT_W + $clog2(SLOT_COUNT + 1);
  localparam logic [ADDR_W-1:0] SLOT_LAST = ADDR_W'(SLOT_COUNT - 1);
  localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'((2 ** (OUT_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] ACC_MIN = -ACC_MAX - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] PUSH_Q  = ACC_W'(4);

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_POS    = 3'd1;
  localparam logic [2:0] S_SPRING = 3'd2;
  localparam logic [2:0] S_SLOT   = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  // configuration registers
  logic       spring_en_r;
  logic [2:0] coef_low_r;
  logic [2:0] coef_high_r;
  logic [7:0] clip_r;
  logic [7:0] db_low_r;
  logic [7:0] db_high_r;
  logic [9:0] range_lim_r;

  // control state
  logic [2:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        last_pos_r, last_pos_nxt;

  // datapath registers
  logic [10:0]             x_r, x_nxt;
  logic [7:0]              pos_r, pos_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic [OUT_W-1:0]        out_force_r, out_force_nxt;

  // slot memory interface
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  slot_t             mem_wslot;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  slot_t             rd_slot;

  // input decode
  logic                     accept;
  logic [4:0]               ld_idx_ext;
  logic signed [AXIS_W-1:0] axis;
  logic signed [12:0]       axis13, lim13, clamped, x_full;
  logic                     push_hi, push_lo;

  // position multiply
  logic [32:0] pos_prod;

  // spring terms
  logic                    sp_below, sp_above;
  logic [7:0]              sp_diff;
  logic [12:0]             sp_mag, sp_clip4, sp_sat;
  logic signed [ACC_W-1:0] spring_val;

  // slot force terms
  logic signed [8:0]       c_lvl;
  logic [7:0]              d_delta;
  logic [7:0]              d_k;
  logic                    d_flip;
  logic signed [16:0]      d_prod, d_val;
  logic signed [ACC_W-1:0] slot_val;
  logic                    is_damper;

  // result saturation
  logic [OUT_W-1:0] sat_force;

  wffm_slot_mem #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_slot_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_slot (mem_wslot),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_slot (rd_slot)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spring_en_r <= 1'b0;
      coef_low_r  <= '0;
      coef_high_r <= '0;
      clip_r      <= '0;
      db_low_r    <= DB_LOW_RST;
      db_high_r   <= DB_HIGH_RST;
      range_lim_r <= RANGE_LIM_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SPRING_EN: spring_en_r <= cfg_wdata[0];
        CFG_COEF_LOW:  coef_low_r  <= cfg_wdata[2:0];
        CFG_COEF_HIGH: coef_high_r <= cfg_wdata[2:0];
        CFG_CLIP:      clip_r      <= cfg_wdata[7:0];
        CFG_DB_LOW:    db_low_r    <= cfg_wdata[7:0];
        CFG_DB_HIGH:   db_high_r   <= cfg_wdata[7:0];
        CFG_RANGE_LIM: range_lim_r <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  // handshake and slot load
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    ld_idx_ext = 5'(in_tdata[F_IDX_LO +: 2]);
    mem_we     = accept && (in_tuser == KIND_LOAD) && (ld_idx_ext < 5'(SLOT_COUNT));
    mem_waddr  = ld_idx_ext[ADDR_W-1:0];
    mem_wslot  = '{en:   in_tdata[F_EN_LO],
                   kind: in_tdata[F_KIND_LO +: 4],
                   p_d:  in_tdata[F_PD_LO +: 8],
                   p_c:  in_tdata[F_PC_LO +: 8],
                   p_b:  in_tdata[F_PB_LO +: 8],
                   p_a:  in_tdata[F_PA_LO +: 8]};
  end

  // sample front end: limit push and clamped, offset axis
  always_comb begin
    axis    = $signed(in_tdata[F_AXIS_LO +: AXIS_W]);
    axis13  = {axis[AXIS_W-1], axis};
    lim13   = $signed({3'b000, range_lim_r});
    push_hi = axis13 > lim13;
    push_lo = axis13 < -lim13;
    if (axis13 > AXIS_FULL) begin
      clamped = AXIS_FULL;
    end else if (axis13 < -AXIS_FULL) begin
      clamped = -AXIS_FULL;
    end else begin
      clamped = axis13;
    end
    x_full = clamped + AXIS_FULL;
  end

  // position scaling by reciprocal multiply
  assign pos_prod = 33'(x_r) * 33'(POS_MUL);

  // default spring outside the dead band, low side first
  always_comb begin
    sp_below = pos_r < db_low_r;
    sp_above = pos_r > db_high_r;
    sp_diff  = sp_below ? (db_low_r - pos_r) : (pos_r - db_high_r);
    sp_mag   = 13'(coef_q(sp_below ? coef_low_r : coef_high_r)) * 13'(sp_diff);
    sp_clip4 = 13'({clip_r, 2'b00});
    sp_sat   = (sp_mag < sp_clip4) ? sp_mag : sp_clip4;
    if (sp_below) begin
      spring_val = -$signed(ACC_W'(sp_sat));
    end else if (sp_above) begin
      spring_val = $signed(ACC_W'(sp_sat));
    end else begin
      spring_val = '0;
    end
  end

  // force of the slot just read
  always_comb begin
    c_lvl   = $signed({1'b0, rd_slot.p_a}) - CONST_MID;
    d_delta = pos_r - last_pos_r;
    d_k     = d_delta[7] ? rd_slot.p_c : rd_slot.p_a;
    d_flip  = d_delta[7] ? (rd_slot.p_d != 8'd0) : (rd_slot.p_b != 8'd0);
    d_prod  = 17'($signed({1'b0, d_k})) * 17'($signed(d_delta));
    d_val   = d_flip ? -d_prod : d_prod;
    is_damper = rd_slot.en && (rd_slot.kind == FK_DAMPER);
    slot_val = '0;
    if (rd_slot.en) begin
      case (rd_slot.kind)
        FK_CONST:  slot_val = {{(ACC_W-11){c_lvl[8]}}, c_lvl, 2'b00};
        FK_DAMPER: slot_val = {{(ACC_W-19){d_val[16]}}, d_val, 2'b00};
        FK_AUTO:   slot_val = $signed(ACC_W'({rd_slot.p_d, 2'b00}));
        FK_SPRING: slot_val = '0;
        default:   slot_val = '0;
      endcase
    end
  end

  // saturate the total to the output range
  always_comb begin
    if (acc_r > ACC_MAX) begin
      sat_force = ACC_MAX[OUT_W-1:0];
    end else if (acc_r < ACC_MIN) begin
      sat_force = ACC_MIN[OUT_W-1:0];
    end else begin
      sat_force = acc_r[OUT_W-1:0];
    end
  end

  // sample sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    last_pos_nxt  = last_pos_r;
    x_nxt         = x_r;
    pos_nxt       = pos_r;
    acc_nxt       = acc_r;
    out_force_nxt = out_force_r;
    out_valid_nxt = out_valid_r && !out_tready;
    mem_re        = 1'b0;
    mem_raddr     = '0;
    case (state_r)
      S_IDLE: begin
        if (accept && (in_tuser == KIND_SAMPLE)) begin
          x_nxt = x_full[10:0];
          if (push_hi) begin
            acc_nxt = PUSH_Q;
          end else if (push_lo) begin
            acc_nxt = -PUSH_Q;
          end else begin
            acc_nxt = '0;
          end
          state_nxt = S_POS;
        end
      end
      S_POS: begin
        pos_nxt   = pos_prod[POS_SHIFT +: 8];
        mem_re    = 1'b1;
        cnt_nxt   = '0;
        state_nxt = spring_en_r ? S_SPRING : S_DONE;
      end
      S_SPRING: begin
        acc_nxt   = acc_r + spring_val;
        state_nxt = S_SLOT;
      end
      S_SLOT: begin
        acc_nxt = acc_r + slot_val;
        if (is_damper) begin
          last_pos_nxt = pos_r;
        end
        if (cnt_r == SLOT_LAST) begin
          state_nxt = S_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = cnt_r + ADDR_W'(1);
          cnt_nxt   = cnt_r + ADDR_W'(1);
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_force_nxt = sat_force;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      last_pos_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      last_pos_r  <= last_pos_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    x_r         <= x_nxt;
    pos_r       <= pos_nxt;
    acc_r       <= acc_nxt;
    out_force_r <= out_force_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_force_r);

  // slot counter stays inside the table while slots are visited
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SLOT) |-> (cnt_r <= SLOT_LAST))
    else $error("slot counter beyond last slot");

  // damper memory only moves while a slot is being evaluated
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(last_pos_r) |-> ($past(state_r) == S_SLOT))
    else $error("damper last position changed outside slot visit");

  // a waiting result is never overwritten by the next one
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_valid_r && !out_tready) |=>
      (state_r == S_DONE && $stable(out_force_r)))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

// ===== dv/wffm_force_checker.sv =====
// wffm_force_checker: predicts mixer forces from the observed traffic and compares results
`timescale 1ns / 100ps

module wffm_force_checker #(
  parameter int SLOT_COUNT = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  // slot_index[1:0], slot_enable[2], force_kind[6:3], param_a[14:7],
  // param_b[22:15], param_c[30:23], param_d[38:31], axis_milli[50:39], zero pad
  input  logic [wffm_pkg::IN_TDATA_W-1:0]  in_tdata,
  // kind[0]
  input  logic                             in_tuser,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  // force_quarters[19:0], zero pad
  input  logic [wffm_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                             cfg_we,
  input  logic [wffm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wffm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output int                               mismatch_count,
  output int                               pending_results
);
  import wffm_pkg::*;

  localparam int LEVEL_MID    = 128;
  localparam int FORCE_MAX    = 524287;
  localparam int FORCE_MIN    = -524288;
  localparam int REPORT_LIMIT = 10;

  // spring slope per position step, in quarters
  int spring_step_q [8] = '{1, 2, 3, 4, 6, 8, 12, 16};

  // mirrored configuration
  logic       spring_on;
  logic [2:0] coef_sel_low;
  logic [2:0] coef_sel_high;
  logic [7:0] spring_cap;
  logic [7:0] band_low;
  logic [7:0] band_high;
  logic [9:0] push_limit;

  // mirrored slot table and shared damper memory
  slot_t      force_slots [SLOT_COUNT];
  logic [7:0] damper_prev;

  logic signed [OUT_W-1:0] force_due [$];

  // total force for one axis sample; advances the damper memory
  function automatic logic signed [OUT_W-1:0] mixed_force(input logic signed [AXIS_W-1:0] axis);
    int         a;
    int         total;
    int         pos;
    int         mag;
    int         cap;
    int         d;
    int         k;
    int         v;
    logic [7:0] step8;
    a = axis;
    total = 0;
    // range-limit push uses the unclamped axis
    if (a > int'(push_limit)) total += 4;
    if (a < -int'(push_limit)) total -= 4;
    a = (a > 1000) ? 1000 : ((a < -1000) ? -1000 : a);
    pos = ((a + 1000) * 255) / 2000;
    if (spring_on) begin
      cap = int'(spring_cap) * 4;
      // low side wins when the band is inverted
      if (pos < int'(band_low)) begin
        mag = spring_step_q[coef_sel_low] * (int'(band_low) - pos);
        total -= (mag < cap) ? mag : cap;
      end else if (pos > int'(band_high)) begin
        mag = spring_step_q[coef_sel_high] * (pos - int'(band_high));
        total += (mag < cap) ? mag : cap;
      end
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (force_slots[i].en) begin
          case (force_slots[i].kind)
            FK_CONST: total += (int'(force_slots[i].p_a) - LEVEL_MID) * 4;
            FK_DAMPER: begin
              step8 = 8'(pos) - damper_prev;
              d = int'($signed(step8));
              damper_prev = 8'(pos);
              if (d < 0) begin
                k = force_slots[i].p_c;
                v = (force_slots[i].p_d != 0) ? -(k * d) : k * d;
              end else begin
                k = force_slots[i].p_a;
                v = (force_slots[i].p_b != 0) ? -(k * d) : k * d;
              end
              total += v * 4;
            end
            FK_AUTO: total += int'(force_slots[i].p_d) * 4;
            default: ;
          endcase
        end
      end
    end
    if (total > FORCE_MAX) total = FORCE_MAX;
    if (total < FORCE_MIN) total = FORCE_MIN;
    return OUT_W'(total);
  endfunction

  task automatic note_mismatch(input string what, input int want, input int got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
  endtask

  always @(posedge clk) begin
    logic signed [OUT_W-1:0] want;
    int                      slot_no;
    if (!rst_n) begin
      spring_on      = 1'b0;
      coef_sel_low   = '0;
      coef_sel_high  = '0;
      spring_cap     = '0;
      band_low       = DB_LOW_RST;
      band_high      = DB_HIGH_RST;
      push_limit     = RANGE_LIM_RST;
      damper_prev    = '0;
      for (int i = 0; i < SLOT_COUNT; i++) force_slots[i] = '0;
      force_due.delete();
      mismatch_count = 0;
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_SPRING_EN: spring_on     = cfg_wdata[0];
          CFG_COEF_LOW:  coef_sel_low  = cfg_wdata[2:0];
          CFG_COEF_HIGH: coef_sel_high = cfg_wdata[2:0];
          CFG_CLIP:      spring_cap    = cfg_wdata[7:0];
          CFG_DB_LOW:    band_low      = cfg_wdata[7:0];
          CFG_DB_HIGH:   band_high     = cfg_wdata[7:0];
          CFG_RANGE_LIM: push_limit    = cfg_wdata[9:0];
          default: ;
        endcase
      end
      // accepted input item
      if (in_tvalid && in_tready) begin
        if (in_tuser == KIND_SAMPLE) begin
          force_due.push_back(mixed_force(in_tdata[F_AXIS_LO +: AXIS_W]));
        end else begin
          slot_no = in_tdata[F_IDX_LO +: 2];
          if (slot_no < SLOT_COUNT) begin
            force_slots[slot_no].en   = in_tdata[F_EN_LO];
            force_slots[slot_no].kind = in_tdata[F_KIND_LO +: 4];
            force_slots[slot_no].p_a  = in_tdata[F_PA_LO +: 8];
            force_slots[slot_no].p_b  = in_tdata[F_PB_LO +: 8];
            force_slots[slot_no].p_c  = in_tdata[F_PC_LO +: 8];
            force_slots[slot_no].p_d  = in_tdata[F_PD_LO +: 8];
          end
        end
      end
      // accepted result item
      if (out_tvalid && out_tready) begin
        if (force_due.size() == 0) begin
          note_mismatch("force with none pending", 0, $signed(out_tdata[OUT_W-1:0]));
        end else begin
          want = force_due.pop_front();
          if ($signed(out_tdata[OUT_W-1:0]) !== want)
            note_mismatch("force mismatch", want, $signed(out_tdata[OUT_W-1:0]));
        end
      end
    end
    pending_results <= force_due.size();
  end

endmodule

// ===== dv/wheel_force_feedback_mixer_top_tb.sv =====
// wheel_force_feedback_mixer_top_tb: stimulus, flow control and verdict for the force mixer
`timescale 1ns / 100ps

module wheel_force_feedback_mixer_top_tb;
  import wffm_pkg::*;

  localparam int SLOT_COUNT      = 4;
  localparam int SETTLE_CYCLES   = SLOT_COUNT + 12;
  localparam int SETTING_COUNT   = 9;
  localparam int ITEMS_PER_PHASE = 200;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  int mismatch_count;
  int pending_results;
  int send_idle_pct = 0;
  int hold_pct = 0;
  int prev_axis = 0;

  wheel_force_feedback_mixer_top #(.SLOT_COUNT(SLOT_COUNT)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  wffm_force_checker #(.SLOT_COUNT(SLOT_COUNT)) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // result side back-pressure
  always @(posedge clk) begin
    out_tready <= (int'($urandom_range(99)) >= hold_pct);
  end

  // offer one item and hold it until accepted
  task automatic push_item(input logic kind, input logic [IN_TDATA_W-1:0] word);
    while (int'($urandom_range(99)) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
  endtask

  // random filler in the fields an item does not use
  function automatic logic [IN_TDATA_W-1:0] noise_word();
    logic [IN_TDATA_W-1:0] word;
    word = '0;
    word[F_AXIS_LO+AXIS_W-1:0] = (F_AXIS_LO+AXIS_W)'({$urandom(), $urandom()});
    return word;
  endfunction

  task automatic send_sample(input int axis);
    logic [IN_TDATA_W-1:0] word;
    word = noise_word();
    word[F_AXIS_LO +: AXIS_W] = AXIS_W'(axis);
    push_item(KIND_SAMPLE, word);
  endtask

  task automatic load_slot(input logic [1:0] idx, input logic en, input logic [3:0] kind,
                           input logic [7:0] pa, input logic [7:0] pb,
                           input logic [7:0] pc, input logic [7:0] pd);
    logic [IN_TDATA_W-1:0] word;
    word = noise_word();
    word[F_IDX_LO +: 2]  = idx;
    word[F_EN_LO]        = en;
    word[F_KIND_LO +: 4] = kind;
    word[F_PA_LO +: 8]   = pa;
    word[F_PB_LO +: 8]   = pb;
    word[F_PC_LO +: 8]   = pc;
    word[F_PD_LO +: 8]   = pd;
    push_item(KIND_LOAD, word);
  endtask

  // stop sending, wait for every pending force and let the block go idle
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one register write per cycle; the caller lowers cfg_we
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(value);
    @(posedge clk);
  endtask

  // configuration for each phase, extremes first
  task automatic apply_setting(input int phase);
    int en;
    int lo;
    int hi;
    int cap;
    int dbl;
    int dbh;
    int lim;
    en  = ($urandom_range(4) != 0);
    lo  = $urandom_range(7);
    hi  = $urandom_range(7);
    cap = $urandom_range(255);
    dbl = $urandom_range(255);
    dbh = $urandom_range(255);
    lim = $urandom_range(1000);
    case (phase)
      0: begin
        en = 1; lo = 0; hi = 7; cap = 255; dbl = 127; dbh = 128; lim = 1000;
      end
      1: begin
        en = 1; lo = 7; hi = 0; cap = 0; dbl = 0; dbh = 255; lim = 0;
      end
      2: en = 0;
      // inverted dead band
      3: begin
        en = 1; lo = 7; hi = 7; cap = 255; dbl = 200; dbh = 50; lim = 500;
      end
      4: begin
        en = 1; dbl = 255; dbh = 0;
      end
      default: ;
    endcase
    write_reg(CFG_SPRING_EN, en);
    write_reg(CFG_COEF_LOW, lo);
    write_reg(CFG_COEF_HIGH, hi);
    write_reg(CFG_CLIP, cap);
    write_reg(CFG_DB_LOW, dbl);
    write_reg(CFG_DB_HIGH, dbh);
    write_reg(CFG_RANGE_LIM, lim);
    // a write to an unmapped index must change nothing
    if (phase == 0) write_reg(CFG_UNUSED, 10'h3FF);
    cfg_we <= 1'b0;
  endtask

  // axis: slow motion for the damper, jumps and out-of-range values
  function automatic int pick_axis();
    int r;
    int a;
    r = $urandom_range(9);
    if (r < 4) begin
      a = prev_axis + int'($urandom_range(80)) - 40;
      a = (a > 2000) ? 2000 : ((a < -2000) ? -2000 : a);
    end else if (r < 8) begin
      a = int'($urandom_range(2000)) - 1000;
    end else begin
      a = int'($urandom_range(4000)) - 2000;
    end
    prev_axis = a;
    return a;
  endfunction

  task automatic random_load();
    logic [3:0] kind;
    case ($urandom_range(3))
      0:       kind = FK_DAMPER;
      1:       kind = FK_CONST;
      2:       kind = FK_AUTO;
      default: kind = 4'($urandom_range(15));
    endcase
    load_slot(2'($urandom_range(3)), ($urandom_range(3) != 0), kind,
              8'($urandom_range(255)),
              $urandom_range(1) ? 8'($urandom_range(255)) : 8'h00,
              8'($urandom_range(255)),
              $urandom_range(1) ? 8'($urandom_range(255)) : 8'h00);
  endtask

  // main sequence
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // spring off: only the range-limit push shows
    send_sample(-2000);
    send_sample(-1001);
    send_sample(0);
    send_sample(1001);
    send_sample(2000);
    drain();
    apply_setting(0);

    // every slot type, two dampers sharing one memory
    load_slot(2'd0, 1'b1, FK_CONST, 8'hFF, 8'h00, 8'h00, 8'h00);
    load_slot(2'd1, 1'b1, FK_DAMPER, 8'hFF, 8'h00, 8'hFF, 8'hFF);
    load_slot(2'd2, 1'b1, FK_DAMPER, 8'h03, 8'hFF, 8'h07, 8'h00);
    load_slot(2'd3, 1'b1, FK_AUTO, 8'h00, 8'h00, 8'h00, 8'hFF);
    send_sample(-2000);
    send_sample(2000);
    send_sample(0);
    send_sample(-1000);
    send_sample(1000);
    load_slot(2'd0, 1'b1, FK_CONST, 8'h00, 8'hFF, 8'hFF, 8'hFF);
    load_slot(2'd1, 1'b1, FK_SPRING, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    load_slot(2'd3, 1'b1, 4'hF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    load_slot(2'd2, 1'b0, FK_DAMPER, 8'hFF, 8'h00, 8'hFF, 8'h00);
    send_sample(-1001);
    send_sample(1001);
    send_sample(500);

    // random phases over several settings and idle patterns
    for (int phase = 0; phase < SETTING_COUNT; phase++) begin
      drain();
      apply_setting(phase);
      case (phase / 3)
        0:       begin send_idle_pct = 32; hold_pct = 76; end
        1:       begin send_idle_pct = 76; hold_pct = 32; end
        default: begin send_idle_pct = 0;  hold_pct = 0;  end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // now and then let the pipeline run dry
        if ($urandom_range(99) == 0) drain();
        if ($urandom_range(3) == 0) random_load();
        else send_sample(pick_axis());
      end
    end

    drain();
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // run limit
  initial begin
    #6_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
